[rtl/pcfd_pkg.sv]
package pcfd_pkg;

  localparam int CHANNELS_DEF     = 2;
  localparam int COUNTER_BITS_DEF = 16;

  localparam int CAP_W   = 16;
  localparam int FREQ_W  = 28;
  localparam int DUTY_W  = 15;
  localparam int CPS_W   = 20;
  localparam int STALE_W = 16;
  localparam int MS_W    = 16;
  localparam int CFG_W   = 20;

  localparam int DUTY_PCT   = 100;
  localparam int PROD_EXTRA = 7;
  localparam int DUTY_FRAC  = 8;

  localparam logic [CPS_W-1:0]   CPS_RESET   = 20'd10000;
  localparam logic [STALE_W-1:0] STALE_RESET = 16'd5000;
  localparam logic [DUTY_W-1:0]  DUTY_FULL   = 15'd25600;
  localparam logic [MS_W-1:0]    MS_MAX      = 16'hFFFF;

  localparam int DIV_W      = FREQ_W;
  localparam int DIV_STEP_W = 5;
  localparam logic [DIV_STEP_W-1:0] FREQ_STEPS = 5'd28;
  localparam logic [DIV_STEP_W-1:0] DUTY_STEPS = 5'd15;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic REG_CPS   = 1'b0;
  localparam logic REG_STALE = 1'b1;

  localparam logic [2:0] OP_IGNORE = 3'd0;
  localparam logic [2:0] OP_TICK   = 3'd1;
  localparam logic [2:0] OP_FALL   = 3'd2;
  localparam logic [2:0] OP_FIRST  = 3'd3;
  localparam logic [2:0] OP_RISE   = 3'd4;

  typedef struct packed {
    logic             cmd;
    logic             channel;
    logic [CAP_W-1:0] capture_time;
  } in_item_t;

  typedef struct packed {
    logic              out_channel;
    logic [FREQ_W-1:0] frequency_q8;
    logic [DUTY_W-1:0] duty_q8;
    logic              duty_stale;
    logic              updated;
  } out_item_t;

  typedef struct packed {
    logic [2:0]       op;
    logic             channel;
    logic [CAP_W-1:0] capture_time;
  } op_t;

  typedef struct packed {
    logic             we;
    logic             index;
    logic [CFG_W-1:0] wdata;
  } cfg_wr_t;

endpackage

[rtl/pwm_capture_frequency_duty_core.sv]
// PWM input capture: period, frequency and duty for each channel.
//
// Input channel (in_valid / in_stall / in_item): an edge capture carries the
// counter value at that edge; a tick item marks one millisecond for all
// channels. Edges of a channel alternate rising, falling, rising.
// Config port (cfg_we / cfg_index / cfg_wdata): index 0 sets counter ticks per
// second, index 1 the stale timeout in ms. Write only while the block is idle.
// Result channel (out_valid / out_stall / out_item): one result per item, in
// order, with the channel's last frequency and duty.
// Flow: ticks, falling edges and first rising edges go from acceptance through
// an execute state and a report state to a valid result. A measuring rising
// edge with a nonzero period also runs the frequency division and then the duty
// division, both on one shared restoring divider at one quotient bit per cycle;
// the duty division is skipped when no falling edge lies inside the period.
// One item is worked at a time; a two-entry queue ahead keeps taking items.
// A stalled result holds in the output register; the back end waits with the
// next finished result until it is taken, and the input stalls when the
// queue fills. Reset clears all channel state and restores the registers.
module pwm_capture_frequency_duty_core #(
  parameter int CHANNELS     = pcfd_pkg::CHANNELS_DEF,
  parameter int COUNTER_BITS = pcfd_pkg::COUNTER_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  pcfd_pkg::in_item_t           in_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output pcfd_pkg::out_item_t          out_item,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [pcfd_pkg::CFG_W-1:0]   cfg_wdata
);
  import pcfd_pkg::*;

  logic    push;
  op_t     push_op;
  logic    full;
  logic    pop;
  logic    pop_valid;
  op_t     pop_op;
  cfg_wr_t cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.wdata = cfg_wdata;

  pcfd_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .full     (full),
    .push     (push),
    .push_op  (push_op)
  );

  pcfd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_op   (push_op),
    .full      (full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_op    (pop_op)
  );

  pcfd_back #(
    .CHANNELS     (CHANNELS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .op_valid  (pop_valid),
    .op_in     (pop_op),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

[rtl/pcfd_div.sv]
module pcfd_div #(
  parameter int COUNTER_BITS = pcfd_pkg::COUNTER_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [pcfd_pkg::DIV_W-1:0]           n_init,
  input  logic [COUNTER_BITS-1:0]              rem_init,
  input  logic [COUNTER_BITS-1:0]              divisor,
  input  logic [pcfd_pkg::DIV_STEP_W-1:0]      steps,
  output logic                                 busy,
  output logic [pcfd_pkg::DIV_W-1:0]           quot
);
  import pcfd_pkg::*;

  logic [DIV_W-1:0]        n_r;
  logic [COUNTER_BITS-1:0] rem_r;
  logic [COUNTER_BITS-1:0] d_r;
  logic [DIV_STEP_W-1:0]   cnt_r;
  logic                    busy_r;
  logic [COUNTER_BITS:0]   rem_sh;
  logic [COUNTER_BITS:0]   diff;
  logic                    ge;

  assign rem_sh = {rem_r, n_r[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, d_r};
  assign diff   = rem_sh - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      n_r    <= n_init;
      rem_r  <= rem_init;
      d_r    <= divisor;
      cnt_r  <= steps;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      n_r   <= {n_r[DIV_W-2:0], ge};
      rem_r <= ge ? diff[COUNTER_BITS-1:0] : rem_sh[COUNTER_BITS-1:0];
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quot = n_r;

endmodule

[rtl/pcfd_back.sv]
module pcfd_back #(
  parameter int CHANNELS     = pcfd_pkg::CHANNELS_DEF,
  parameter int COUNTER_BITS = pcfd_pkg::COUNTER_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pcfd_pkg::cfg_wr_t   cfg,
  input  logic                op_valid,
  input  pcfd_pkg::op_t       op_in,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output pcfd_pkg::out_item_t out_item
);
  import pcfd_pkg::*;

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TW = (COUNTER_BITS < CAP_W) ? COUNTER_BITS : CAP_W;
  localparam int PW = COUNTER_BITS + PROD_EXTRA;
  localparam int DW = PW + DUTY_FRAC;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_FSTART = 3'd2;
  localparam logic [2:0] S_FWAIT  = 3'd3;
  localparam logic [2:0] S_DWAIT  = 3'd4;
  localparam logic [2:0] S_RPT    = 3'd5;

  logic [2:0]              state_r;
  op_t                     op_r;
  logic [COUNTER_BITS-1:0] period_r;
  logic [COUNTER_BITS-1:0] high_r;
  logic                    duty_ok_r;
  logic                    upd_r;
  logic [PW-1:0]           prod_r;
  logic [CPS_W-1:0]        cps_r;
  logic [STALE_W-1:0]      stale_tmo_r;

  logic [COUNTER_BITS-1:0] prev_rise_r [CHANNELS];
  logic [COUNTER_BITS-1:0] falling_r   [CHANNELS];
  logic [CHANNELS-1:0]     fall_seen_r;
  logic [FREQ_W-1:0]       freq_r      [CHANNELS];
  logic [DUTY_W-1:0]       duty_r      [CHANNELS];
  logic [MS_W-1:0]         ms_r        [CHANNELS];

  logic                    out_valid_r;
  out_item_t               out_item_r;

  logic [CH_IDX_W-1:0]     idx;
  logic [COUNTER_BITS-1:0] t_cnt;
  logic [COUNTER_BITS-1:0] period_c;
  logic [COUNTER_BITS-1:0] high_c;
  logic [DW-1:0]           dfull;
  logic                    duty_go;
  logic                    stale;
  out_item_t               res;

  logic                    div_start;
  logic [DIV_W-1:0]        div_n;
  logic [COUNTER_BITS-1:0] div_rem;
  logic [DIV_STEP_W-1:0]   div_steps;
  logic                    div_busy;
  logic [DIV_W-1:0]        div_quot;

  assign idx      = CH_IDX_W'(op_r.channel);
  assign t_cnt    = COUNTER_BITS'(op_r.capture_time[TW-1:0]);
  assign period_c = t_cnt - prev_rise_r[idx];
  assign high_c   = falling_r[idx] - prev_rise_r[idx];
  assign dfull    = {prod_r, {DUTY_FRAC{1'b0}}};
  assign duty_go  = duty_ok_r && (high_r < period_r);
  assign pop      = (state_r == S_IDLE) && op_valid;

  always_comb begin
    div_start = 1'b0;
    div_n     = {cps_r, {DUTY_FRAC{1'b0}}};
    div_rem   = '0;
    div_steps = FREQ_STEPS;
    if (state_r == S_FSTART) begin
      div_start = 1'b1;
    end else if (state_r == S_FWAIT && !div_busy && duty_go) begin
      div_start = 1'b1;
      div_n     = {dfull[DUTY_W-1:0], {(DIV_W-DUTY_W){1'b0}}};
      div_rem   = dfull[DW-1:DUTY_W];
      div_steps = DUTY_STEPS;
    end
  end

  pcfd_div #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .n_init   (div_n),
    .rem_init (div_rem),
    .divisor  (period_r),
    .steps    (div_steps),
    .busy     (div_busy),
    .quot     (div_quot)
  );

  always_comb begin
    stale           = ms_r[idx] > stale_tmo_r;
    res             = '0;
    res.out_channel = op_r.channel;
    if (op_r.op != OP_IGNORE) begin
      res.frequency_q8 = freq_r[idx];
      res.duty_q8      = stale ? '0 : duty_r[idx];
      res.duty_stale   = stale;
      res.updated      = upd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      upd_r       <= 1'b0;
      cps_r       <= CPS_RESET;
      stale_tmo_r <= STALE_RESET;
      fall_seen_r <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        prev_rise_r[c] <= '0;
        falling_r[c]   <= '0;
        freq_r[c]      <= '0;
        duty_r[c]      <= '0;
        ms_r[c]        <= '0;
      end
    end else begin
      if (cfg.we) begin
        unique case (cfg.index)
          REG_CPS:   cps_r       <= cfg.wdata[CPS_W-1:0];
          REG_STALE: stale_tmo_r <= cfg.wdata[STALE_W-1:0];
          default: ;
        endcase
      end
      if (!out_stall && state_r != S_RPT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (op_valid) begin
            op_r    <= op_in;
            upd_r   <= 1'b0;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_RPT;
          unique case (op_r.op)
            OP_TICK: begin
              for (int c = 0; c < CHANNELS; c++) begin
                if (ms_r[c] != MS_MAX) begin
                  ms_r[c] <= ms_r[c] + 1'b1;
                end
              end
            end
            OP_FALL: begin
              falling_r[idx]   <= t_cnt;
              fall_seen_r[idx] <= 1'b1;
              ms_r[idx]        <= '0;
            end
            OP_FIRST: begin
              prev_rise_r[idx] <= t_cnt;
              ms_r[idx]        <= '0;
            end
            OP_RISE: begin
              period_r         <= period_c;
              high_r           <= high_c;
              duty_ok_r        <= fall_seen_r[idx] && (falling_r[idx] != t_cnt);
              prev_rise_r[idx] <= t_cnt;
              ms_r[idx]        <= '0;
              if (period_c != '0) begin
                state_r <= S_FSTART;
              end
            end
            default: ;
          endcase
        end
        S_FSTART: begin
          prod_r  <= PW'(high_r) * PW'(DUTY_PCT);
          state_r <= S_FWAIT;
        end
        S_FWAIT: begin
          if (!div_busy) begin
            freq_r[idx] <= div_quot;
            upd_r       <= 1'b1;
            if (duty_go) begin
              state_r <= S_DWAIT;
            end else begin
              if (duty_ok_r) begin
                duty_r[idx] <= DUTY_FULL;
              end
              state_r <= S_RPT;
            end
          end
        end
        S_DWAIT: begin
          if (!div_busy) begin
            duty_r[idx] <= div_quot[DUTY_W-1:0];
            state_r     <= S_RPT;
          end
        end
        S_RPT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_item_r  <= res;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[rtl/pcfd_fifo.sv]
module pcfd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pcfd_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output pcfd_pkg::op_t pop_op
);
  import pcfd_pkg::*;

  op_t        mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full      = count_r == 2'd2;
  assign pop_valid = count_r != 2'd0;
  assign pop_op    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        mem_r[wr_ptr_r] <= push_op;
        wr_ptr_r        <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

[rtl/pcfd_front.sv]
module pcfd_front #(
  parameter int CHANNELS = pcfd_pkg::CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pcfd_pkg::in_item_t in_item,
  input  logic               full,
  output logic               push,
  output pcfd_pkg::op_t      push_op
);
  import pcfd_pkg::*;

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [CHANNELS-1:0] expect_fall_r;
  logic [CHANNELS-1:0] rise_seen_r;
  logic [CH_IDX_W-1:0] idx;
  logic                ch_ok;
  logic                is_edge;

  assign idx      = CH_IDX_W'(in_item.channel);
  assign ch_ok    = 32'(in_item.channel) < CHANNELS;
  assign is_edge  = ch_ok && (in_item.cmd == CMD_EDGE);
  assign in_stall = full;
  assign push     = in_valid && !full;

  always_comb begin
    push_op.channel      = in_item.channel;
    push_op.capture_time = in_item.capture_time;
    if (!ch_ok) begin
      push_op.op = OP_IGNORE;
    end else if (in_item.cmd == CMD_TICK) begin
      push_op.op = OP_TICK;
    end else if (expect_fall_r[idx]) begin
      push_op.op = OP_FALL;
    end else if (rise_seen_r[idx]) begin
      push_op.op = OP_RISE;
    end else begin
      push_op.op = OP_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_fall_r <= '0;
      rise_seen_r   <= '0;
    end else if (push && is_edge) begin
      expect_fall_r[idx] <= ~expect_fall_r[idx];
      if (!expect_fall_r[idx]) begin
        rise_seen_r[idx] <= 1'b1;
      end
    end
  end

endmodule

[rtl/pcfd_checker.sv]
module pcfd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input pcfd_pkg::out_item_t out_item
);
  import pcfd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.duty_q8 <= DUTY_FULL)
    else $error("duty above full scale");

  a_stale_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.duty_stale |-> out_item.duty_q8 == '0)
    else $error("stale duty not zero");

  a_update_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.updated |-> !out_item.duty_stale)
    else $error("new measurement reported stale");

endmodule

bind pwm_capture_frequency_duty_core pcfd_checker u_pcfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
